// ----- design/brm_pkg.sv -----
// Package for the banked ROM mapper with bit reversal.
// Holds sizes, mode codes, bus address decodes and small helper functions.
// No dependencies.
package brm_pkg;

    localparam int ROM_BYTES  = 262144;
    localparam int PAGE_BYTES = 8192;

    localparam int PAGE_AW = $clog2(PAGE_BYTES);   // offset bits inside a page
    localparam int ROM_AW  = $clog2(ROM_BYTES);    // ROM byte address bits
    localparam int SIZE_W  = ROM_AW + 1;           // holds ROM_BYTES itself
    localparam int PG_W    = SIZE_W - PAGE_AW;     // holds the page count
    localparam int CNT_W   = $clog2(ROM_AW + 1);   // divider step counter

    localparam int CFG_W   = 19;
    localparam int MODE_W  = 2;
    localparam int ADDR_W  = 16;
    localparam int DATA_W  = 8;
    localparam int LIDX_W  = 18;
    localparam int PGSEL_W = 8;

    // item modes
    localparam logic [MODE_W-1:0] MODE_READ  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_WRITE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_LOAD  = 2'd2;

    // bus address decode points
    localparam logic [ADDR_W-1:0] ADDR_PAGE1   = 16'h2000;
    localparam logic [ADDR_W-1:0] ADDR_BANK_4K = 16'h4000;
    localparam logic [ADDR_W-1:0] ADDR_BANK_6K = 16'h6000;
    localparam logic [ADDR_W-1:0] ADDR_BANK_8K = 16'h8000;
    localparam logic [ADDR_W-1:0] ADDR_BANK_AK = 16'hA000;
    localparam logic [ADDR_W-1:0] ADDR_TOP     = 16'hC000;
    localparam logic [ADDR_W-1:0] ADDR_PAIR_LO = 16'hFFFE;
    localparam logic [ADDR_W-1:0] ADDR_PAIR_HI = 16'hFFFF;

    // bank register slots
    localparam int BANK_8K = 0;
    localparam int BANK_AK = 1;
    localparam int BANK_4K = 2;
    localparam int BANK_6K = 3;
    localparam int NBANKS  = 4;

    localparam logic [DATA_W-1:0] OPEN_BUS = 8'hFF;

    function automatic logic [DATA_W-1:0] flip_byte(input logic [DATA_W-1:0] v);
        logic [DATA_W-1:0] r;
        for (int i = 0; i < DATA_W; i++) begin
            r[i] = v[DATA_W-1-i];
        end
        return r;
    endfunction

    // number of 8 KiB pages covering size bytes (rounded up)
    function automatic logic [PG_W-1:0] page_count(input logic [SIZE_W-1:0] size);
        return size[SIZE_W-1:PAGE_AW] + PG_W'(|size[PAGE_AW-1:0]);
    endfunction

endpackage

// ----- design/banked_rom_mapper_bit_reverse_unit.sv -----
// Top level of the banked ROM mapper with bit reversal.
// Holds the sequencer, the shared restoring remainder unit and the ROM store.
// Depends on brm_pkg.
//
// A banked or fixed-page read runs 8 remainder steps for the page, ROM_AW = 18
//   for the address, one ROM read and the output state before m_valid rises;
//   a read above BFFF or with no ROM goes straight to the output state.
// The input is not ready for a new item until a read has left the output state;
//   the single subtract/compare unit runs both remainders one bit per cycle.
//   Writes and loads are taken in the idle state and leave it idle.
//   A result held by m_ready low keeps the next read in the output state.
// Reset (aresetn low, synchronous): sequencer idle, no result pending, bank
//   registers and ROM size cleared. ROM contents are kept as they are.
module banked_rom_mapper_bit_reverse_unit
    import brm_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    // configuration: ROM size in bytes
    input  logic                cfg_wr_en,
    input  logic [CFG_W-1:0]    cfg_wr_data,
    // item channel
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [MODE_W-1:0]   s_mode,
    input  logic [ADDR_W-1:0]   s_address,
    input  logic [DATA_W-1:0]   s_write_data,
    input  logic [LIDX_W-1:0]   s_load_index,
    // result channel
    output logic                m_valid,
    input  logic                m_ready,
    output logic [DATA_W-1:0]   m_read_data
);

    // Sequencer: one-hot
    typedef enum logic [4:0] {
        ST_IDLE     = 5'b00001,
        ST_MOD_PAGE = 5'b00010,   // page number mod page count
        ST_MOD_ADDR = 5'b00100,   // physical address mod ROM size
        ST_MEM      = 5'b01000,   // ROM read in flight
        ST_OUT      = 5'b10000    // hand result to the output register
    } state_t;

    state_t                  state_reg, state_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;

    // Shared remainder unit: partial remainder, dividend shifter, divisor
    logic [SIZE_W-1:0]       rem_reg, rem_next;
    logic [ROM_AW-1:0]       dvd_reg, dvd_next;
    logic [SIZE_W-1:0]       dsor_reg, dsor_next;

    // Per-read context
    logic [SIZE_W-1:0]       size_reg, size_next;
    logic [PAGE_AW-1:0]      off_reg, off_next;
    logic                    rev_reg, rev_next;
    logic                    ff_reg, ff_next;

    // Architectural state
    logic [CFG_W-1:0]        rom_size_reg;
    logic [PGSEL_W-1:0]      bank_reg  [NBANKS];
    logic [PGSEL_W-1:0]      bank_next [NBANKS];

    // Output register
    logic                    m_valid_reg, m_valid_next;
    logic [DATA_W-1:0]       m_data_reg, m_data_next;

    // ROM store
    logic [DATA_W-1:0]       rom_mem [ROM_BYTES];
    logic [DATA_W-1:0]       rom_rd_reg;
    logic                    load_en;

    // Datapath helpers
    logic [SIZE_W-1:0]       sat_size;
    logic [PGSEL_W-1:0]      pg_sel;
    logic                    rev_sel;
    logic [SIZE_W:0]         trial;
    logic                    trial_ge;
    logic [SIZE_W-1:0]       step_rem;
    logic [ROM_AW-1:0]       phys_addr;
    logic                    accept;

    assign s_ready     = (state_reg == ST_IDLE);
    assign accept      = s_valid && s_ready;
    assign m_valid     = m_valid_reg;
    assign m_read_data = m_data_reg;

    // ROM size saturated to the store
    assign sat_size = (32'(rom_size_reg) > 32'(ROM_BYTES)) ? SIZE_W'(ROM_BYTES)
                                                           : SIZE_W'(rom_size_reg);

    // Page and reversal selection for a read at s_address
    always_comb begin
        pg_sel  = '0;
        rev_sel = 1'b0;
        if (s_address < ADDR_PAGE1) begin
            pg_sel = '0;
        end else if (s_address < ADDR_BANK_4K) begin
            pg_sel = PGSEL_W'(1);
        end else if (s_address < ADDR_BANK_8K) begin
            pg_sel  = (s_address < ADDR_BANK_6K) ? bank_reg[BANK_4K] : bank_reg[BANK_6K];
            rev_sel = bank_reg[BANK_4K][PGSEL_W-1];
        end else begin
            pg_sel  = (s_address < ADDR_BANK_AK) ? bank_reg[BANK_8K] : bank_reg[BANK_AK];
            rev_sel = bank_reg[BANK_8K][PGSEL_W-1];
        end
    end

    // One restoring step: shift in the next dividend bit, subtract if it fits
    assign trial    = {rem_reg, dvd_reg[ROM_AW-1]};
    assign trial_ge = (trial >= {1'b0, dsor_reg});
    assign step_rem = trial_ge ? SIZE_W'(trial - {1'b0, dsor_reg}) : trial[SIZE_W-1:0];

    // reduced page number placed above the in-page offset
    assign phys_addr = (ROM_AW'(step_rem) << PAGE_AW) | ROM_AW'(off_reg);

    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        rem_next     = rem_reg;
        dvd_next     = dvd_reg;
        dsor_next    = dsor_reg;
        size_next    = size_reg;
        off_next     = off_reg;
        rev_next     = rev_reg;
        ff_next      = ff_reg;
        bank_next    = bank_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    case (s_mode)
                        MODE_READ: begin
                            size_next = sat_size;
                            off_next  = s_address[PAGE_AW-1:0];
                            rev_next  = rev_sel;
                            ff_next   = (s_address >= ADDR_TOP) || (sat_size == '0);
                            dvd_next  = {pg_sel, {(ROM_AW-PGSEL_W){1'b0}}};
                            rem_next  = '0;
                            dsor_next = SIZE_W'(page_count(sat_size));
                            cnt_next  = CNT_W'(PGSEL_W);
                            state_next = ((s_address >= ADDR_TOP) || (sat_size == '0))
                                         ? ST_OUT : ST_MOD_PAGE;
                        end
                        MODE_WRITE: begin
                            case (s_address)
                                ADDR_BANK_4K: bank_next[BANK_4K] = s_write_data;
                                ADDR_BANK_6K: bank_next[BANK_6K] = s_write_data;
                                ADDR_BANK_8K: bank_next[BANK_8K] = s_write_data;
                                ADDR_BANK_AK: bank_next[BANK_AK] = s_write_data;
                                ADDR_PAIR_LO: begin
                                    bank_next[BANK_4K] = {s_write_data[PGSEL_W-2:0], 1'b0};
                                    bank_next[BANK_6K] = {s_write_data[PGSEL_W-2:0], 1'b1};
                                end
                                ADDR_PAIR_HI: begin
                                    bank_next[BANK_8K] = {s_write_data[PGSEL_W-2:0], 1'b0};
                                    bank_next[BANK_AK] = {s_write_data[PGSEL_W-2:0], 1'b1};
                                end
                                default: ;
                            endcase
                        end
                        default: ;   // loads go straight to the ROM; unused mode dropped
                    endcase
                end
            end
            ST_MOD_PAGE: begin
                rem_next = step_rem;
                dvd_next = dvd_reg << 1;
                cnt_next = cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1)) begin
                    dvd_next   = phys_addr;
                    rem_next   = '0;
                    dsor_next  = size_reg;
                    cnt_next   = CNT_W'(ROM_AW);
                    state_next = ST_MOD_ADDR;
                end
            end
            ST_MOD_ADDR: begin
                rem_next = step_rem;
                dvd_next = dvd_reg << 1;
                cnt_next = cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1)) begin
                    state_next = ST_MEM;
                end
            end
            ST_MEM: begin
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    if (ff_reg) begin
                        m_data_next = OPEN_BUS;
                    end else begin
                        m_data_next = rev_reg ? flip_byte(rom_rd_reg) : rom_rd_reg;
                    end
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            cnt_reg      <= '0;
            m_valid_reg  <= 1'b0;
            rom_size_reg <= '0;
            for (int i = 0; i < NBANKS; i++) begin
                bank_reg[i] <= '0;
            end
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
            bank_reg    <= bank_next;
            if (cfg_wr_en) begin
                rom_size_reg <= cfg_wr_data;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        rem_reg    <= rem_next;
        dvd_reg    <= dvd_next;
        dsor_reg   <= dsor_next;
        size_reg   <= size_next;
        off_reg    <= off_next;
        rev_reg    <= rev_next;
        ff_reg     <= ff_next;
        m_data_reg <= m_data_next;
    end

    // ROM store: one write port for loads, one registered read port
    assign load_en = accept && (s_mode == MODE_LOAD) && (32'(s_load_index) < ROM_BYTES);

    always_ff @(posedge aclk) begin
        if (load_en) begin
            rom_mem[ROM_AW'(s_load_index)] <= s_write_data;
        end
        rom_rd_reg <= rom_mem[rem_reg[ROM_AW-1:0]];
    end

    // Checks
    // final address remainder always lands inside the loaded ROM
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_MEM) |-> (rem_reg < size_reg))
        else $error("ROM address remainder not below ROM size");

    // reduced page number stays below the page count
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_MOD_ADDR && cnt_reg == CNT_W'(ROM_AW))
        |-> ((dvd_reg >> PAGE_AW) < ROM_AW'(page_count(size_reg))))
        else $error("page remainder not below page count");

    // a result appears only out of the output state
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == ST_OUT))
        else $error("result raised outside output state");

    // step counter never runs out while a remainder is in progress
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_MOD_PAGE || state_reg == ST_MOD_ADDR) |-> (cnt_reg != '0))
        else $error("remainder step counter ran out");

endmodule

// ----- tb/sv/banked_rom_mapper_bit_reverse_unit_tb.sv -----
// Self-checking testbench for banked_rom_mapper_bit_reverse_unit.
// Drives reads, bank writes and ROM loads with a built-in predictor and scoreboard.
// Depends on brm_pkg and the mapper RTL.
module banked_rom_mapper_bit_reverse_unit_tb
    import brm_pkg::*;
();

    // mode value that the block ignores
    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

    localparam int BEAT_GOAL   = 1450;     // useful input beats for the whole run
    localparam int SETTLE_CYC  = 40;       // longer than the read latency
    localparam int CYCLE_LIMIT = 400000;
    localparam int STALL_CYC   = 300;      // long output hold-off

    typedef struct {
        logic [ADDR_W-1:0] addr;
        logic [DATA_W-1:0] data;
    } read_exp_t;

    logic               aclk;
    logic               aresetn;
    logic               cfg_wr_en;
    logic [CFG_W-1:0]   cfg_wr_data;
    logic               s_valid;
    logic               s_ready;
    logic [MODE_W-1:0]  s_mode;
    logic [ADDR_W-1:0]  s_address;
    logic [DATA_W-1:0]  s_write_data;
    logic [LIDX_W-1:0]  s_load_index;
    logic               m_valid;
    logic               m_ready;
    logic [DATA_W-1:0]  m_read_data;

    banked_rom_mapper_bit_reverse_unit uut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_mode       (s_mode),
        .s_address    (s_address),
        .s_write_data (s_write_data),
        .s_load_index (s_load_index),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_read_data  (m_read_data)
    );

    // ------------------------------------------------------------------
    // Mapper shadow state: bank registers, ROM size, ROM image and a map
    // of which ROM bytes have been loaded (reads only go to loaded bytes).
    // ------------------------------------------------------------------
    logic [PGSEL_W-1:0] bank_sel [NBANKS];
    logic [CFG_W-1:0]   rom_size_reg;
    logic [DATA_W-1:0]  rom_image  [ROM_BYTES];
    bit                 rom_loaded [ROM_BYTES];

    read_exp_t read_expect[$];   // read data still owed by the block

    // run bookkeeping
    int  cycle_count;
    int  mismatches;
    int  reads_checked;
    int  useful_beats;
    int  loads_sent;
    int  bank_writes;
    int  sizes_tried;
    int  ready_hold;             // receiver hold-off, counted down by its own process
    bit  steady;                 // no idling on either side while set

    // ------------------------------------------------------------------
    // Clock, watchdog
    // ------------------------------------------------------------------
    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d reads outstanding",
                     cycle_count, read_expect.size());
            $display("tb: failure");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    // Effective ROM length: register value clipped to the store size.
    function automatic int rom_len();
        return (int'(rom_size_reg) > ROM_BYTES) ? ROM_BYTES : int'(rom_size_reg);
    endfunction

    // ROM byte a CPU read touches, or -1 when the read never reaches the store.
    function automatic int rom_phys(input logic [ADDR_W-1:0] a);
        int len;
        int npages;
        int pg;
        int phys;
        len = rom_len();
        if (len == 0 || a >= ADDR_TOP) return -1;
        if (a < ADDR_PAGE1)        pg = 0;
        else if (a < ADDR_BANK_4K) pg = 1;
        else if (a < ADDR_BANK_6K) pg = int'(bank_sel[BANK_4K]);
        else if (a < ADDR_BANK_8K) pg = int'(bank_sel[BANK_6K]);
        else if (a < ADDR_BANK_AK) pg = int'(bank_sel[BANK_8K]);
        else                       pg = int'(bank_sel[BANK_AK]);
        npages = (len + PAGE_BYTES - 1) / PAGE_BYTES;
        // page wraps on the page count, then the byte address on the ROM length
        phys = (pg % npages) * PAGE_BYTES + int'(a) % PAGE_BYTES;
        if (phys >= len) phys = phys % len;
        return phys;
    endfunction

    function automatic logic [DATA_W-1:0] predict_read(input logic [ADDR_W-1:0] a);
        int                p;
        logic [DATA_W-1:0] d;
        logic              mirror;
        p = rom_phys(a);
        d = (p < 0) ? OPEN_BUS : rom_image[p];
        // bit 7 of the first register of each 16 KiB half mirrors that half
        if (a >= ADDR_BANK_4K && a < ADDR_BANK_8K) mirror = bank_sel[BANK_4K][7];
        else if (a >= ADDR_BANK_8K && a < ADDR_TOP) mirror = bank_sel[BANK_8K][7];
        else mirror = 1'b0;
        return mirror ? {d[0], d[1], d[2], d[3], d[4], d[5], d[6], d[7]} : d;
    endfunction

    function automatic bit is_bank_addr(input logic [ADDR_W-1:0] a);
        return a == ADDR_BANK_4K || a == ADDR_BANK_6K || a == ADDR_BANK_8K ||
               a == ADDR_BANK_AK || a == ADDR_PAIR_LO || a == ADDR_PAIR_HI;
    endfunction

    // Update shadow state for one accepted beat; queue read data.
    function automatic void mapper_accept(input logic [MODE_W-1:0] mode,
                                          input logic [ADDR_W-1:0] a,
                                          input logic [DATA_W-1:0] v,
                                          input logic [LIDX_W-1:0] idx);
        read_exp_t e;
        case (mode)
            MODE_READ: begin
                e.addr = a;
                e.data = predict_read(a);
                read_expect.push_back(e);
            end
            MODE_WRITE: begin
                case (a)
                    ADDR_BANK_4K: bank_sel[BANK_4K] = v;
                    ADDR_BANK_6K: bank_sel[BANK_6K] = v;
                    ADDR_BANK_8K: bank_sel[BANK_8K] = v;
                    ADDR_BANK_AK: bank_sel[BANK_AK] = v;
                    // pair writes: even page 2n, odd page 2n+1, both mod 256
                    ADDR_PAIR_LO: begin
                        bank_sel[BANK_4K] = {v[6:0], 1'b0};
                        bank_sel[BANK_6K] = {v[6:0], 1'b1};
                    end
                    ADDR_PAIR_HI: begin
                        bank_sel[BANK_8K] = {v[6:0], 1'b0};
                        bank_sel[BANK_AK] = {v[6:0], 1'b1};
                    end
                    default: ;
                endcase
            end
            MODE_LOAD: begin
                rom_image[idx]  = v;
                rom_loaded[idx] = 1'b1;
            end
            default: ;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Result checker: every accepted result against the oldest expectation
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        read_exp_t e;
        if (aresetn && m_valid && m_ready) begin
            if (read_expect.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected read beat: read_data=%02h", m_read_data);
            end else begin
                e = read_expect.pop_front();
                reads_checked++;
                if (m_read_data !== e.data) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("read %04h: read_data expected %02h, got %02h",
                                 e.addr, e.data, m_read_data);
                end
            end
        end
    end

    // Receiver: random stalls, hold-off stretches, steady stretches.
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (ready_hold > 0) begin
                m_ready = 1'b0;
                ready_hold--;
            end else if (steady) begin
                m_ready = 1'b1;
            end else begin
                m_ready = ($urandom_range(99) >= 12);
            end
        end
    end

    // ------------------------------------------------------------------
    // Shared sender tasks
    // ------------------------------------------------------------------
    // Offer one beat and hold it until accepted; valid stays high afterwards
    // so back-to-back beats need no bubble.
    task automatic send_beat(input logic [MODE_W-1:0] mode,
                             input logic [ADDR_W-1:0] a,
                             input logic [DATA_W-1:0] v,
                             input logic [LIDX_W-1:0] idx);
        @(negedge aclk);
        while (!steady && $urandom_range(99) < 12) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_mode       = mode;
        s_address    = a;
        s_write_data = v;
        s_load_index = idx;
        s_valid      = 1'b1;
        do @(posedge aclk); while (!s_ready);
        mapper_accept(mode, a, v, idx);
        if (mode == MODE_READ || mode == MODE_LOAD ||
            (mode == MODE_WRITE && is_bank_addr(a)))
            useful_beats++;
        if (mode == MODE_LOAD) loads_sent++;
        if (mode == MODE_WRITE && is_bank_addr(a)) bank_writes++;
    endtask

    task automatic release_bus();
        @(negedge aclk);
        s_valid = 1'b0;
    endtask

    // Sender pause: drop valid and wait for every owed read plus settle time
    // (writes and loads leave no result to wait on).
    task automatic wait_idle();
        release_bus();
        while (read_expect.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYC) @(posedge aclk);
    endtask

    // CPU read; loads the target ROM byte first if it was never written.
    task automatic read_at(input logic [ADDR_W-1:0] a);
        int p;
        p = rom_phys(a);
        if (p >= 0 && !rom_loaded[p])
            send_beat(MODE_LOAD, ADDR_W'($urandom), DATA_W'($urandom), LIDX_W'(p));
        send_beat(MODE_READ, a, DATA_W'($urandom), LIDX_W'($urandom));
    endtask

    task automatic bus_store(input logic [ADDR_W-1:0] a, input logic [DATA_W-1:0] v);
        send_beat(MODE_WRITE, a, v, LIDX_W'($urandom));
    endtask

    task automatic set_rom_size(input logic [CFG_W-1:0] v);
        wait_idle();
        @(negedge aclk);
        cfg_wr_en   = 1'b1;
        cfg_wr_data = v;
        @(negedge aclk);
        cfg_wr_en    = 1'b0;
        rom_size_reg = v;
        sizes_tried++;
    endtask

    function automatic logic [ADDR_W-1:0] pick_read_addr();
        int r;
        r = $urandom_range(99);
        if (r < 25) return ADDR_W'($urandom_range(16'h3FFF));
        if (r < 85) return ADDR_W'($urandom_range(16'hBFFF, 16'h4000));
        return ADDR_W'($urandom_range(16'hFFFF, 16'hC000));
    endfunction

    function automatic logic [ADDR_W-1:0] pick_bank_addr();
        case ($urandom_range(5))
            0: return ADDR_BANK_4K;
            1: return ADDR_BANK_6K;
            2: return ADDR_BANK_8K;
            3: return ADDR_BANK_AK;
            4: return ADDR_PAIR_LO;
            default: return ADDR_PAIR_HI;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    // No ROM: every read, including mirrored halves, answers FF.
    task automatic test_empty_rom();
        read_at(16'h0000);
        read_at(16'h3FFF);
        bus_store(ADDR_BANK_4K, 8'h80);
        bus_store(ADDR_BANK_8K, 8'h80);
        read_at(16'h5555);
        read_at(16'hBFFF);
        read_at(ADDR_TOP);
        read_at(16'hFFFF);
        wait_idle();
    endtask

    // Fixed pages, every bank register, pair writes, mirroring, wrap past
    // the end of a ROM that is not a whole number of pages.
    task automatic test_fixed_and_banked();
        set_rom_size(CFG_W'(3 * PAGE_BYTES + 100));   // 4 pages, last one short
        read_at(16'h0000);
        read_at(16'h1FFF);
        read_at(ADDR_PAGE1);
        read_at(16'h3FFF);
        bus_store(ADDR_BANK_4K, 8'h82);               // page 2, lower half mirrored
        bus_store(ADDR_BANK_6K, 8'h03);               // short last page
        read_at(ADDR_BANK_4K);
        read_at(16'h5FFF);
        read_at(ADDR_BANK_6K);
        read_at(16'h7FFF);                            // beyond ROM length, wraps
        bus_store(ADDR_BANK_8K, 8'h7F);
        bus_store(ADDR_BANK_AK, 8'hFF);
        read_at(ADDR_BANK_8K);
        read_at(16'hBFFF);
        bus_store(ADDR_PAIR_LO, 8'hFF);               // 2n wraps to FE/FF
        bus_store(ADDR_PAIR_HI, 8'h80);               // 2n wraps to 00/01
        read_at(16'h4123);
        read_at(16'h6FFF);
        read_at(16'h9000);
        read_at(16'hA001);
        bus_store(16'h4001, 8'h55);                   // not a bank address
        send_beat(MODE_UNUSED, 16'h4000, 8'hAA, LIDX_W'($urandom));
        read_at(ADDR_TOP);
        read_at(16'hFFFF);
        wait_idle();
    endtask

    // ROM length corners: one byte, just under/over a page, full store,
    // and a register value that must clip to the store size.
    task automatic test_size_extremes();
        logic [CFG_W-1:0] sizes [5];
        sizes = '{CFG_W'(1), CFG_W'(PAGE_BYTES - 1), CFG_W'(PAGE_BYTES + 1),
                  CFG_W'(ROM_BYTES), {CFG_W{1'b1}}};
        send_beat(MODE_LOAD, 16'hFFFF, 8'hC3, {LIDX_W{1'b1}});   // top ROM byte
        foreach (sizes[i]) begin
            set_rom_size(sizes[i]);
            bus_store(ADDR_BANK_8K, 8'h1F);           // page 31 when ROM is full
            bus_store(ADDR_BANK_AK, 8'hFF);
            read_at(16'h9FFF);
            read_at(16'hBFFF);
            repeat (3) read_at(pick_read_addr());
        end
        wait_idle();
    endtask

    // Hold the output off for a long stretch while reads keep coming, so
    // the block fills and stalls its input; then pause until all drain.
    task automatic test_output_stall();
        set_rom_size(CFG_W'(8 * PAGE_BYTES));
        @(negedge aclk);
        ready_hold = STALL_CYC;
        repeat (16) read_at(pick_read_addr());
        wait_idle();
    endtask

    // Mixed random traffic over several ROM sizes; one phase runs with
    // no idling on either side.
    task automatic test_random_traffic();
        int               quota;
        int               stop_at;
        int               r;
        logic [CFG_W-1:0] len;
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: len = CFG_W'($urandom_range(6 * PAGE_BYTES, 1));
                1: len = CFG_W'(ROM_BYTES);
                2: len = CFG_W'($urandom_range(16 * PAGE_BYTES, PAGE_BYTES));
                3: len = {CFG_W{1'b1}};
                4: len = CFG_W'($urandom_range(PAGE_BYTES - 1, 1));
                default: len = CFG_W'($urandom_range((1 << CFG_W) - 1, 1));
            endcase
            set_rom_size(len);
            steady  = (ph == 2);
            quota   = (BEAT_GOAL - useful_beats) / (6 - ph);
            stop_at = useful_beats + quota;
            while (useful_beats < stop_at) begin
                r = $urandom_range(99);
                if (r < 50)
                    read_at(pick_read_addr());
                else if (r < 72)
                    bus_store(pick_bank_addr(), DATA_W'($urandom));
                else if (r < 90)
                    send_beat(MODE_LOAD, ADDR_W'($urandom), DATA_W'($urandom),
                              LIDX_W'($urandom));
                else if (r < 95)
                    send_beat(MODE_UNUSED, ADDR_W'($urandom), DATA_W'($urandom),
                              LIDX_W'($urandom));
                else
                    bus_store(ADDR_W'($urandom), DATA_W'($urandom));
            end
            steady = 1'b0;
        end
        wait_idle();
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        aresetn      = 1'b0;
        cfg_wr_en    = 1'b0;
        cfg_wr_data  = '0;
        s_valid      = 1'b0;
        s_mode       = MODE_READ;
        s_address    = '0;
        s_write_data = '0;
        s_load_index = '0;
        rom_size_reg = '0;
        foreach (bank_sel[i]) bank_sel[i] = '0;
        ready_hold   = 0;
        steady       = 1'b0;

        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_empty_rom();
        test_fixed_and_banked();
        test_size_extremes();
        test_output_stall();
        test_random_traffic();

        $display("run: %0d beats (%0d loads, %0d bank writes), %0d reads checked,",
                 useful_beats, loads_sent, bank_writes, reads_checked);
        $display("     %0d ROM sizes, %0d mismatches", sizes_tried, mismatches);
        if (mismatches == 0 && read_expect.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
